// ----- src/vpd_pkg.sv -----
// shared types, constants and helpers for the velocity to position delta block
`default_nettype none
package vpd_pkg;

	localparam int FRAC      = 16;
	localparam int ANG_W     = 21;
	localparam int POS_W     = 48;
	localparam int CFG_IDX_W = 4;

	localparam logic [26:0] DEG2RAD    = 27'd74961321;
	localparam longint      PI_Q32     = 64'd13493037705;
	localparam logic signed [22:0] PI_FX  = 23'((PI_Q32 + (64'd1 << (31 - FRAC))) >> (32 - FRAC));
	localparam logic signed [22:0] TWO_PI = 23'(2 * ((PI_Q32 + (64'd1 << (31 - FRAC))) >> (32 - FRAC)));

	localparam logic [19:0] SCALE_MS   = 20'd1000;
	localparam logic [19:0] SCALE_S    = 20'd1000000;
	localparam logic [31:0] NS_PER_US  = 32'd1000;
	localparam logic [31:0] US_PER_S   = 32'd1000000;
	localparam logic [63:0] US_HALF    = 64'd500000;
	localparam logic [31:0] CONF_SCALE = 32'(100 << FRAC);
	localparam logic [31:0] U32_MAX    = 32'hFFFF_FFFF;

	localparam logic [CFG_IDX_W-1:0] CFG_MOUNT = 4'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TUNIT = 4'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LIMIT = 4'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ATT_MUL,
		ST_SENS_WHOLE,
		ST_SENS_FRAC,
		ST_SENS_CHK,
		ST_FALL_DIV,
		ST_STAMP_DIV,
		ST_POS_MUL,
		ST_POS_DIV,
		ST_ANGLE,
		ST_YAW_WRAP,
		ST_CONF,
		ST_CONF_MUL,
		ST_CONF_DIV,
		ST_DONE
	} st_t;

	typedef struct packed {
		logic go;
		logic is_div;
	} ser_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} ser_rsp_t;

	function automatic logic signed [ANG_W-1:0] sat_ang(input logic signed [22:0] v);
		logic signed [22:0] hi;
		logic signed [22:0] lo;
		hi = 23'sd1048575;
		lo = -23'sd1048576;
		if (v > hi) begin
			return hi[ANG_W-1:0];
		end else if (v < lo) begin
			return lo[ANG_W-1:0];
		end
		return v[ANG_W-1:0];
	endfunction

endpackage
`default_nettype wire

// ----- src/vpd_serial.sv -----
// bit-serial unsigned multiplier (32 steps) and restoring divider (64 steps)
`default_nettype none
module vpd_serial import vpd_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire ser_req_t    req,
	input  wire logic [63:0] opa,
	input  wire logic [31:0] opb,
	output ser_rsp_t         rsp,
	output logic      [63:0] res
);

	logic [63:0] w_q;
	logic [31:0] rem_q;
	logic [31:0] a_q;
	logic [31:0] b_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        div_q;
	logic        done_q;

	logic [32:0] mul_sum;
	logic [32:0] trial;
	logic [32:0] diff;
	logic        ge;
	logic        last_step;

	always_comb begin
		mul_sum   = {1'b0, w_q[63:32]} + ({1'b0, a_q} & {33{w_q[0]}});
		trial     = {rem_q, w_q[63]};
		diff      = trial - {1'b0, b_q};
		ge        = (trial >= {1'b0, b_q});
		last_step = div_q ? (cnt_q == 6'd63) : (cnt_q == 6'd31);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			div_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.go) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				div_q  <= req.is_div;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (last_step) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.go) begin
			w_q   <= req.is_div ? opa : {32'd0, opb};
			a_q   <= opa[31:0];
			b_q   <= opb;
			rem_q <= '0;
		end else if (busy_q) begin
			if (div_q) begin
				rem_q <= ge ? diff[31:0] : trial[31:0];
				w_q   <= {w_q[62:0], ge};
			end else begin
				// add-and-shift, carry drops into the high half
				w_q <= {mul_sum, w_q[31:1]};
			end
		end
	end

	assign res      = w_q;
	assign rsp.busy = busy_q;
	assign rsp.done = done_q;

endmodule
`default_nettype wire

// ----- src/velocity_to_position_delta.sv -----
// top level: attitude store, time step, position and attitude deltas, confidence
// From transfer to result, every product and quotient of an attitude update or a velocity
// sample goes through one shared bit-serial unit (for a velocity sample: time step, stamp,
// three positions, confidence), and a velocity sample may also wrap its yaw change. A new
// item is taken once the previous one is finished; a finished result waits in the output
// register without holding input.
`default_nettype none
module velocity_to_position_delta import vpd_pkg::*; (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire logic                        operation,
	input  wire logic signed [25:0]          roll_deg,
	input  wire logic signed [25:0]          pitch_deg,
	input  wire logic signed [25:0]          yaw_deg,
	input  wire logic signed [23:0]          vel_x,
	input  wire logic signed [23:0]          vel_y,
	input  wire logic signed [23:0]          vel_z,
	input  wire logic                        vel_trusted,
	input  wire logic                        values_finite,
	input  wire logic [47:0]                 sensor_time,
	input  wire logic [62:0]                 stamp_ns,
	input  wire logic signed [23:0]          merit,
	input  wire logic                        cfg_valid,
	output logic                             cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]        cfg_index,
	input  wire logic [23:0]                 cfg_data,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic [53:0]                      stamp_us,
	output logic [31:0]                      step_us,
	output logic signed [ANG_W-1:0]          angle_dx,
	output logic signed [ANG_W-1:0]          angle_dy,
	output logic signed [ANG_W-1:0]          angle_dz,
	output logic signed [POS_W-1:0]          pos_dx,
	output logic signed [POS_W-1:0]          pos_dy,
	output logic signed [POS_W-1:0]          pos_dz,
	output logic [22:0]                      confidence
);

	st_t state_q, state_d;
	logic issued_q;
	logic [1:0] idx_q;

	logic        mount_q;
	logic        tunit_q;
	logic [23:0] lim_q;

	logic signed [ANG_W-1:0] latest_q [3];
	logic signed [ANG_W-1:0] prev_q [3];
	logic                    seen_q;
	logic                    seeded_q;
	logic [62:0]             last_q;

	logic signed [25:0] deg_q [3];
	logic signed [23:0] vel_q [3];
	logic               finite_q;
	logic [47:0]        t_q;
	logic [62:0]        stamp_q;
	logic signed [23:0] merit_q;

	logic [51:0]        whole_q;
	logic [FRAC+19:0]   fs_q;
	logic [31:0]        td_q;
	logic [53:0]        tusec_q;
	logic [63:0]        prod_q;
	logic signed [POS_W-1:0] pos_q [3];
	logic signed [ANG_W-1:0] ang_q [3];
	logic signed [22:0] yr_q;
	logic [22:0]        conf_q;

	logic                    out_valid_q;
	logic [53:0]             o_tusec_q;
	logic [31:0]             o_td_q;
	logic signed [ANG_W-1:0] o_ang_q [3];
	logic signed [POS_W-1:0] o_pos_q [3];
	logic [22:0]             o_conf_q;

	ser_req_t    ser_req;
	ser_rsp_t    ser_rsp;
	logic [63:0] opa;
	logic [31:0] opb;
	logic [63:0] res;

	logic signed [25:0] deg_sel;
	logic [25:0]        deg_mag;
	logic signed [23:0] vel_sel;
	logic [23:0]        vel_mag;
	logic [19:0]        scale;
	logic [FRAC+19:0]   fs_up;
	logic [FRAC+19:0]   fs_rnd;
	logic [52:0]        sum_up;
	logic [52:0]        sum_rnd;
	logic [31:0]        td0;
	logic               stamp_later;
	logic [62:0]        stamp_diff;
	logic signed [54:0] p_s;
	logic signed [54:0] p_rnd;
	logic signed [ANG_W-1:0] rad;
	logic [23:0]        m_pos;
	logic [23:0]        m_clamp;
	logic [23:0]        lim_diff;
	logic signed [22:0] d_roll;
	logic signed [22:0] d_pitch;
	logic signed [22:0] d_yaw;
	logic signed [22:0] yaw_out;
	logic [POS_W-1:0]   pos_val;
	logic               out_free;

	vpd_serial u_serial (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (ser_req),
		.opa    (opa),
		.opb    (opb),
		.rsp    (ser_rsp),
		.res    (res)
	);

	always_comb begin
		deg_sel     = deg_q[idx_q];
		deg_mag     = deg_sel[25] ? 26'(26'd0 - deg_sel) : 26'(deg_sel);
		vel_sel     = vel_q[idx_q];
		vel_mag     = vel_sel[23] ? 24'(24'd0 - vel_sel) : 24'(vel_sel);
		scale       = tunit_q ? SCALE_MS : SCALE_S;
		fs_up       = (fs_q + (FRAC+20)'((1 << FRAC) - 1)) >> FRAC;
		fs_rnd      = (fs_q + (FRAC+20)'(1 << (FRAC - 1))) >> FRAC;
		sum_up      = {1'b0, whole_q} + 53'(fs_up);
		sum_rnd     = {1'b0, whole_q} + 53'(fs_rnd);
		// a sensor time whose exact value would pass 32 bits is not usable
		td0         = ((t_q == '0) || (sum_up > 53'(U32_MAX))) ? 32'd0 : sum_rnd[31:0];
		stamp_later = (stamp_q > last_q);
		stamp_diff  = stamp_q - last_q;
		p_s         = deg_sel[25] ? -$signed({2'b00, res[52:0]}) : $signed({2'b00, res[52:0]});
		p_rnd       = p_s + 55'sd2147483648;
		rad         = sat_ang(p_rnd[54:32]);
		m_pos       = merit_q[23] ? 24'd0 : 24'(merit_q);
		m_clamp     = (m_pos > lim_q) ? lim_q : m_pos;
		lim_diff    = lim_q - m_clamp;
		d_roll      = 23'(latest_q[0]) - 23'(prev_q[0]);
		d_pitch     = 23'(latest_q[1]) - 23'(prev_q[1]);
		d_yaw       = 23'(latest_q[2]) - 23'(prev_q[2]) + PI_FX;
		yaw_out     = yr_q - PI_FX;
		pos_val     = vel_sel[23] ? (POS_W'(0) - POS_W'(res)) : POS_W'(res);
		out_free    = !out_valid_q || !out_stall;
	end

	// sequencer
	always_comb begin
		state_d        = state_q;
		ser_req.go     = 1'b0;
		ser_req.is_div = 1'b0;
		opa            = '0;
		opb            = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (!operation) begin
						state_d = values_finite ? ST_ATT_MUL : ST_IDLE;
					end else if (!vel_trusted) begin
						state_d = ST_IDLE;
					end else if (sensor_time != '0) begin
						state_d = ST_SENS_WHOLE;
					end else begin
						state_d = ST_SENS_CHK;
					end
				end
			end
			ST_ATT_MUL: begin
				ser_req.go = !issued_q;
				opa = 64'(deg_mag);
				opb = 32'(DEG2RAD);
				if (ser_rsp.done && idx_q == 2'd2) begin
					state_d = ST_IDLE;
				end
			end
			ST_SENS_WHOLE: begin
				ser_req.go = !issued_q;
				opa = 64'(t_q[47:FRAC]);
				opb = 32'(scale);
				if (ser_rsp.done) begin
					state_d = ST_SENS_FRAC;
				end
			end
			ST_SENS_FRAC: begin
				ser_req.go = !issued_q;
				opa = 64'(t_q[FRAC-1:0]);
				opb = 32'(scale);
				if (ser_rsp.done) begin
					state_d = ST_SENS_CHK;
				end
			end
			ST_SENS_CHK: begin
				if (td0 == '0 && last_q != '0 && stamp_later) begin
					state_d = ST_FALL_DIV;
				end else if (td0 == '0 || !finite_q) begin
					state_d = ST_IDLE;
				end else begin
					state_d = ST_STAMP_DIV;
				end
			end
			ST_FALL_DIV: begin
				ser_req.go     = !issued_q;
				ser_req.is_div = 1'b1;
				opa = 64'(stamp_diff);
				opb = NS_PER_US;
				if (ser_rsp.done) begin
					state_d = (res == '0 || !finite_q) ? ST_IDLE : ST_STAMP_DIV;
				end
			end
			ST_STAMP_DIV: begin
				ser_req.go     = !issued_q;
				ser_req.is_div = 1'b1;
				opa = 64'(stamp_q);
				opb = NS_PER_US;
				if (ser_rsp.done) begin
					state_d = ST_POS_MUL;
				end
			end
			ST_POS_MUL: begin
				ser_req.go = !issued_q;
				opa = 64'(vel_mag);
				opb = td_q;
				if (ser_rsp.done) begin
					state_d = ST_POS_DIV;
				end
			end
			ST_POS_DIV: begin
				ser_req.go     = !issued_q;
				ser_req.is_div = 1'b1;
				opa = prod_q + US_HALF;
				opb = US_PER_S;
				if (ser_rsp.done) begin
					state_d = (idx_q == 2'd2) ? ST_ANGLE : ST_POS_MUL;
				end
			end
			ST_ANGLE: begin
				state_d = (seen_q && seeded_q) ? ST_YAW_WRAP : ST_CONF;
			end
			ST_YAW_WRAP: begin
				if (yr_q >= 0 && yr_q < TWO_PI) begin
					state_d = ST_CONF;
				end
			end
			ST_CONF: begin
				state_d = (lim_q == '0) ? ST_DONE : ST_CONF_MUL;
			end
			ST_CONF_MUL: begin
				ser_req.go = !issued_q;
				opa = 64'(lim_diff);
				opb = CONF_SCALE;
				if (ser_rsp.done) begin
					state_d = ST_CONF_DIV;
				end
			end
			ST_CONF_DIV: begin
				ser_req.go     = !issued_q;
				ser_req.is_div = 1'b1;
				opa = prod_q + 64'(lim_q >> 1);
				opb = 32'(lim_q);
				if (ser_rsp.done) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			issued_q    <= 1'b0;
			idx_q       <= '0;
			mount_q     <= 1'b0;
			tunit_q     <= 1'b1;
			lim_q       <= 24'd26214;
			latest_q    <= '{default: '0};
			prev_q      <= '{default: '0};
			seen_q      <= 1'b0;
			seeded_q    <= 1'b0;
			last_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ser_req.go) begin
				issued_q <= 1'b1;
			end else if (ser_rsp.done) begin
				issued_q <= 1'b0;
			end
			if (state_q == ST_IDLE) begin
				idx_q <= '0;
			end else if (ser_rsp.done && (state_q == ST_ATT_MUL || state_q == ST_POS_DIV)) begin
				idx_q <= idx_q + 2'd1;
			end
			if (cfg_valid) begin
				case (cfg_index)
					CFG_MOUNT: mount_q <= cfg_data[0];
					CFG_TUNIT: tunit_q <= cfg_data[0];
					CFG_LIMIT: lim_q   <= cfg_data;
					default:   ;
				endcase
			end
			if (state_q == ST_ATT_MUL && ser_rsp.done) begin
				latest_q[idx_q] <= rad;
				if (idx_q == 2'd2) begin
					seen_q <= 1'b1;
				end
			end
			// stamp is taken for the fallback in every case past the validity check
			if (state_q == ST_SENS_CHK && state_d != ST_FALL_DIV) begin
				last_q <= stamp_q;
			end
			if (state_q == ST_FALL_DIV && ser_rsp.done) begin
				last_q <= stamp_q;
			end
			if (state_q == ST_ANGLE && seen_q) begin
				seeded_q <= 1'b1;
				prev_q   <= latest_q;
			end
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			deg_q    <= '{roll_deg, pitch_deg, yaw_deg};
			vel_q    <= '{vel_x, vel_y, vel_z};
			finite_q <= values_finite;
			t_q      <= sensor_time;
			stamp_q  <= stamp_ns;
			merit_q  <= merit;
		end
		if (state_q == ST_SENS_WHOLE && ser_rsp.done) begin
			whole_q <= res[51:0];
		end
		if (state_q == ST_SENS_FRAC && ser_rsp.done) begin
			fs_q <= res[FRAC+19:0];
		end
		if (state_q == ST_SENS_CHK) begin
			td_q <= td0;
		end
		if (state_q == ST_FALL_DIV && ser_rsp.done) begin
			td_q <= (res > 64'(U32_MAX)) ? U32_MAX : res[31:0];
		end
		if (state_q == ST_STAMP_DIV && ser_rsp.done) begin
			tusec_q <= res[53:0];
		end
		if ((state_q == ST_POS_MUL || state_q == ST_CONF_MUL) && ser_rsp.done) begin
			prod_q <= res;
		end
		if (state_q == ST_POS_DIV && ser_rsp.done) begin
			pos_q[idx_q] <= pos_val;
		end
		if (state_q == ST_ANGLE) begin
			yr_q     <= d_yaw;
			ang_q[0] <= (seen_q && seeded_q) ? sat_ang(d_roll) : '0;
			ang_q[1] <= (seen_q && seeded_q) ? sat_ang(d_pitch) : '0;
			ang_q[2] <= '0;
		end
		// yaw change folded into one turn
		if (state_q == ST_YAW_WRAP) begin
			if (yr_q >= TWO_PI) begin
				yr_q <= yr_q - TWO_PI;
			end else if (yr_q < 0) begin
				yr_q <= yr_q + TWO_PI;
			end else begin
				ang_q[2] <= yaw_out[ANG_W-1:0];
			end
		end
		if (state_q == ST_CONF) begin
			conf_q <= '0;
		end
		if (state_q == ST_CONF_DIV && ser_rsp.done) begin
			conf_q <= res[22:0];
		end
		if (state_q == ST_DONE && out_free) begin
			o_tusec_q <= tusec_q;
			o_td_q    <= td_q;
			o_conf_q  <= conf_q;
			if (mount_q) begin
				o_pos_q[0] <= pos_q[2];
				o_pos_q[1] <= pos_q[1];
				o_pos_q[2] <= POS_W'(0) - pos_q[0];
				o_ang_q[0] <= ang_q[2];
				o_ang_q[1] <= ang_q[1];
				o_ang_q[2] <= sat_ang(23'sd0 - 23'(ang_q[0]));
			end else begin
				o_pos_q <= pos_q;
				o_ang_q <= ang_q;
			end
		end
	end

	assign in_stall      = (state_q != ST_IDLE);
	assign cfg_ready     = 1'b1;
	assign out_valid     = out_valid_q;
	assign stamp_us      = o_tusec_q;
	assign step_us       = o_td_q;
	assign angle_dx      = o_ang_q[0];
	assign angle_dy      = o_ang_q[1];
	assign angle_dz      = o_ang_q[2];
	assign pos_dx        = o_pos_q[0];
	assign pos_dy        = o_pos_q[1];
	assign pos_dz        = o_pos_q[2];
	assign confidence    = o_conf_q;

	a_idle_no_issue: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !issued_q)
		else $error("serial op outstanding while idle");

	a_done_when_issued: assert property (@(posedge clk) disable iff (!arst_n)
		ser_rsp.done |-> issued_q)
		else $error("serial unit finished without a request");

	a_go_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		ser_req.go |-> !ser_rsp.busy)
		else $error("serial unit started while busy");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == ST_DONE)
		else $error("result raised outside the done step");

endmodule
`default_nettype wire
